@@ rtl/swb_pkg.sv @@
package swb_pkg;

	// Opcodes of an input word.
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_STOP   = 3'd2;
	localparam logic [2:0] OP_RESET  = 3'd3;
	localparam logic [2:0] OP_STATUS = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	// Status codes of a result word.
	localparam logic [1:0] STAT_RUN     = 2'd0;
	localparam logic [1:0] STAT_BUSY    = 2'd1;
	localparam logic [1:0] STAT_STOPPED = 2'd2;
	localparam logic [1:0] STAT_ERROR   = 2'd3;

	localparam logic [15:0] TPS_RESET = 16'd1000;
	localparam logic [7:0]  SEC_MAX   = 8'd255;

	// One stopwatch as it is kept in the state memory.
	typedef struct packed {
		logic        running;
		logic [15:0] prescale;
		logic [7:0]  seconds;
	} swb_entry_t;

	// Advances one stopwatch by one tick.
	function automatic swb_entry_t swb_advance(swb_entry_t e, logic [15:0] tps);
		swb_entry_t r;
		logic [15:0] nxt;
		r   = e;
		nxt = e.prescale + 16'd1;
		if (e.running) begin
			if (nxt >= tps) begin
				r.prescale = '0;
				if (e.seconds != SEC_MAX) begin
					r.seconds = e.seconds + 8'd1;
				end
			end else begin
				r.prescale = nxt;
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/stopwatch_bank_core.sv @@
// A bank of NUM_STOPWATCHES one-second stopwatches driven by a millisecond tick word.
// Every input word yields exactly one result word. All stopwatch state lives in one
// synchronous memory with one entry per stopwatch, so each word is worked through
// that memory's single read and write port. A tick walks the entries one per cycle,
// reading the next entry while the previous one is written back, and then offers its
// result. A command on one stopwatch reads its entry, then modifies and writes it,
// before offering its result; an out-of-range index or an undefined opcode offers its
// result without a memory access. The input is stalled from acceptance until the
// result has moved into the output register, even if that result is still waiting to
// be taken, and the next word can be accepted once it has. A full output register
// holds the result back and so keeps the input stalled for longer.
// No clearing pass is needed after reset: a valid flag per entry makes an unwritten
// entry read as an idle stopwatch at zero.
module stopwatch_bank_core
	import swb_pkg::*;
#(
	parameter int NUM_STOPWATCHES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  stopwatch_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] ticks_per_second
);

	localparam int AW = NUM_STOPWATCHES > 1 ? $clog2(NUM_STOPWATCHES) : 1;
	localparam int EW = $bits(swb_entry_t);

	// Sequencer states.
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_CMD    = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]           state_q;
	logic [AW-1:0]        walk_q;
	logic [2:0]           op_q;
	logic [AW-1:0]        idx_q;
	logic [15:0]          tps_q;
	logic [NUM_STOPWATCHES-1:0] vld_q;
	logic                 rvld_s1;
	logic [1:0]           res_status_q;
	logic [7:0]           res_seconds_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [7:0]           seconds_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 idx_ok;
	logic                 op_cmd;
	logic                 walk_last;
	logic                 re;
	logic [AW-1:0]        raddr;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [EW-1:0]        rdata;
	swb_entry_t           cur;
	swb_entry_t           upd;
	logic [1:0]           cmd_status;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign idx_ok    = stopwatch_index < 4'(NUM_STOPWATCHES);
	assign op_cmd    = (opcode != OP_TICK) && (opcode <= OP_READ);
	assign walk_last = (walk_q == AW'(NUM_STOPWATCHES - 1));
	assign cfg_ready = 1'b1;

	// The memory reads the first entry of a tick walk or the addressed entry on
	// acceptance, then the following entry on every walk cycle but the last.
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				re    = in_acc && ((opcode == OP_TICK) || (op_cmd && idx_ok));
				raddr = (opcode == OP_TICK) ? '0 : stopwatch_index[AW-1:0];
			end
			S_WALK: begin
				re    = !walk_last;
				raddr = AW'(walk_q + 1'b1);
			end
			default: begin
				re    = 1'b0;
				raddr = '0;
			end
		endcase
	end

	swb_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_STOPWATCHES)
	) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (upd),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// An entry that has never been written is an idle stopwatch at zero.
	assign cur = rvld_s1 ? swb_entry_t'(rdata) : '0;

	// Modify step: a tick advances the entry, a command acts on it.
	always_comb begin
		upd        = cur;
		cmd_status = STAT_RUN;
		if (state_q == S_WALK) begin
			upd = swb_advance(cur, tps_q);
		end else begin
			unique case (op_q)
				OP_START: begin
					if (!cur.running) begin
						upd.seconds = '0;
						upd.running = 1'b1;
						cmd_status  = STAT_RUN;
					end else begin
						cmd_status = STAT_BUSY;
					end
				end
				OP_STOP: begin
					upd.running = 1'b0;
					cmd_status  = STAT_STOPPED;
				end
				OP_RESET: begin
					if (!cur.running) begin
						upd.seconds = '0;
					end
					cmd_status = STAT_RUN;
				end
				default: begin
					cmd_status = cur.running ? STAT_RUN : STAT_STOPPED;
				end
			endcase
		end
	end

	// Write-back happens in the cycle after the read of the same entry; during a walk
	// the read of the next entry runs alongside, so no two accesses collide.
	assign we    = (state_q == S_WALK) || (state_q == S_CMD);
	assign waddr = (state_q == S_WALK) ? walk_q : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_q      <= '0;
			tps_q       <= TPS_RESET;
			vld_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tps_q <= ticks_per_second;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			// A finished result refills the output register in the cycle it is emptied.
			if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						walk_q <= '0;
						if (opcode == OP_TICK) begin
							state_q <= S_WALK;
						end else if (op_cmd && idx_ok) begin
							state_q <= S_CMD;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_WALK: begin
					if (walk_last) begin
						state_q <= S_RESULT;
					end else begin
						walk_q <= AW'(walk_q + 1'b1);
					end
				end
				S_CMD: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the captured command, the pending result and the output word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q          <= opcode;
			idx_q         <= stopwatch_index[AW-1:0];
			res_status_q  <= (opcode == OP_TICK) ? STAT_RUN : STAT_ERROR;
			res_seconds_q <= '0;
		end
		if (state_q == S_CMD) begin
			res_status_q  <= cmd_status;
			res_seconds_q <= upd.seconds;
		end
		if ((state_q == S_RESULT) && out_free) begin
			status_q  <= res_status_q;
			seconds_q <= res_seconds_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign seconds   = seconds_q;

	// The memory is written only while an accepted word is being worked through.
	a_write_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_WALK || state_q == S_CMD))
		else $error("state memory written outside a walk or command");

	// A result word appears only when the sequencer hands one over.
	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_RESULT)
		else $error("result word without a finished item");

	// An accepted word always leaves the idle state on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted word was not taken up");

	// Error results never report a seconds count; ticks do not either, but only errors are checked here.
	a_zero_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_ERROR)) |-> seconds == 8'd0)
		else $error("error result carries a seconds count");

endmodule

@@ rtl/swb_ram.sv @@
module swb_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ tb/sv/stopwatch_bank_checker.sv @@
`timescale 1ns / 100ps

// Watches the word channels of the stopwatch bank, predicts every result from its own
// copy of the stopwatch state and compares each result word against the oldest prediction.
module stopwatch_bank_checker
	import swb_pkg::*;
#(
	parameter int NUM_STOPWATCHES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  stopwatch_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [7:0]  seconds,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] ticks_per_second,
	output int          mismatch_count,
	output int          results_owed
);

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] seconds;
	} sw_result_t;

	logic        sw_running  [NUM_STOPWATCHES];
	logic [15:0] sw_prescale [NUM_STOPWATCHES];
	logic [7:0]  sw_seconds  [NUM_STOPWATCHES];
	logic [15:0] tps_setting;

	sw_result_t owed_results [$];

	// Applies one input word to the stopwatch copy and returns the result it should give.
	function automatic sw_result_t run_stopwatch_word(logic [2:0] op, logic [3:0] idx);
		sw_result_t  r;
		logic [15:0] nxt;
		r.status  = STAT_ERROR;
		r.seconds = '0;
		if (op == OP_TICK) begin
			for (int k = 0; k < NUM_STOPWATCHES; k++) begin
				if (sw_running[k]) begin
					nxt = sw_prescale[k] + 16'd1;
					if (nxt >= tps_setting) begin
						sw_prescale[k] = '0;
						if (sw_seconds[k] != SEC_MAX) begin
							sw_seconds[k] = sw_seconds[k] + 8'd1;
						end
					end else begin
						sw_prescale[k] = nxt;
					end
				end
			end
			r.status = STAT_RUN;
		end else if (op <= OP_READ && idx < NUM_STOPWATCHES) begin
			case (op)
				OP_START: begin
					if (!sw_running[idx]) begin
						sw_seconds[idx] = '0;
						sw_running[idx] = 1'b1;
						r.status = STAT_RUN;
					end else begin
						r.status = STAT_BUSY;
					end
				end
				OP_STOP: begin
					sw_running[idx] = 1'b0;
					r.status = STAT_STOPPED;
				end
				OP_RESET: begin
					if (!sw_running[idx]) begin
						sw_seconds[idx] = '0;
					end
					r.status = STAT_RUN;
				end
				default: begin
					r.status = sw_running[idx] ? STAT_RUN : STAT_STOPPED;
				end
			endcase
			r.seconds = sw_seconds[idx];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sw_result_t want;
		sw_result_t got;
		if (!arst_n) begin
			for (int k = 0; k < NUM_STOPWATCHES; k++) begin
				sw_running[k]  = 1'b0;
				sw_prescale[k] = '0;
				sw_seconds[k]  = '0;
			end
			tps_setting = TPS_RESET;
			owed_results.delete();
			mismatch_count <= 0;
			results_owed   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tps_setting = ticks_per_second;
			end
			// The result is taken before this edge's input word is predicted, so a result
			// can never be matched against a word that went in at the same edge.
			if (out_valid && !out_stall) begin
				got.status  = status;
				got.seconds = seconds;
				if (owed_results.size() == 0) begin
					$display("%0t: result word with none expected: status %0d, seconds %0d",
						$time, got.status, got.seconds);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status || got.seconds !== want.seconds) begin
						if (got.status !== want.status) begin
							$display("%0t: status expected %0d, got %0d",
								$time, want.status, got.status);
						end
						if (got.seconds !== want.seconds) begin
							$display("%0t: seconds expected %0d, got %0d",
								$time, want.seconds, got.seconds);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				owed_results.push_back(run_stopwatch_word(opcode, stopwatch_index));
			end
			results_owed <= owed_results.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Drives the stopwatch bank with a short directed run followed by five random phases,
// each at its own ticks-per-second setting. The checker beside the block predicts and
// compares every result word; this module only makes the stimulus, applies back-pressure
// on the result side and gives the verdict.
module testbench
	import swb_pkg::*;
();

	localparam int NUM_STOPWATCHES = 8;
	// Length of the deliberate result-side hold-off, long enough for the block to fill
	// up and stall its input well before it ends.
	localparam int LONG_HOLD   = 80;
	// Cycles with no word moving on any channel before the run is declared hung.
	localparam int QUIET_LIMIT = 3000;
	// The two opcode values that the block does not define.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic [2:0]  opcode           = OP_TICK;
	logic [3:0]  stopwatch_index  = '0;
	logic        out_stall        = 1'b0;
	logic        cfg_valid        = 1'b0;
	logic [15:0] ticks_per_second = TPS_RESET;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [7:0]  seconds;
	logic        cfg_ready;

	int mismatch_count;
	int results_owed;

	// Idling rates of the two sides, in per cent, and the request for a long hold-off.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	stopwatch_bank_core #(
		.NUM_STOPWATCHES(NUM_STOPWATCHES)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.stopwatch_index (stopwatch_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.seconds         (seconds),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.ticks_per_second(ticks_per_second)
	);

	stopwatch_bank_checker #(
		.NUM_STOPWATCHES(NUM_STOPWATCHES)
	) checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.stopwatch_index (stopwatch_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.seconds         (seconds),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.ticks_per_second(ticks_per_second),
		.mismatch_count  (mismatch_count),
		.results_owed    (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side. A change of hold_req starts a long hold-off that this process counts
	// down itself; otherwise the stall is drawn afresh every cycle at the current rate.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: any word moving on any channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("stopwatch_bank_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one input word, first letting idle cycles pass at the sender's rate, and
	// returns at the edge where the block takes it. Valid stays high on return so that
	// back-to-back words need no gap.
	task automatic send_word(input logic [2:0] op, input logic [3:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= op;
		stopwatch_index <= idx;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Stops offering words and waits until every predicted result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_tps(input logic [15:0] value);
		cfg_valid        <= 1'b1;
		ticks_per_second <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// One random word. Ticks dominate, as they do in use. Among the commands, the churn
	// rate decides how often stopwatches are started, stopped or reset rather than only
	// queried, so a low rate lets counts run on towards saturation. Most indexes are in
	// range; the rest span all sixteen values.
	task automatic send_random_word(input int tick_pct, input int churn_pct);
		logic [2:0] op;
		logic [3:0] idx;
		int         roll;
		roll = $urandom_range(99);
		if (roll < tick_pct) begin
			op = OP_TICK;
		end else if (roll >= 97) begin
			op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
		end else if ($urandom_range(99) < churn_pct) begin
			case ($urandom_range(2))
				0:       op = OP_START;
				1:       op = OP_STOP;
				default: op = OP_RESET;
			endcase
		end else begin
			op = $urandom_range(1) ? OP_STATUS : OP_READ;
		end
		if ($urandom_range(99) < 85) begin
			idx = 4'($urandom_range(NUM_STOPWATCHES - 1));
		end else begin
			idx = 4'($urandom_range(15));
		end
		send_word(op, idx);
	endtask

	// One random phase. The register is only written once the block has gone idle. A
	// phase may also ask for a long result-side hold-off or a full drain part-way through;
	// an index of -1 leaves that out.
	task automatic run_phase(input logic [15:0] tps, input int words, input int tick_pct,
			input int churn_pct, input int hold_at, input int drain_at);
		drain_results();
		write_tps(tps);
		for (int n = 0; n < words; n++) begin
			if (n == hold_at) begin
				hold_req <= hold_req + 1;
			end
			if (n == drain_at) begin
				drain_results();
			end
			send_random_word(tick_pct, churn_pct);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles lightly while the receiver stalls heavily.
		send_idle_pct <= 18;
		recv_idle_pct <= 59;

		// Directed words at the reset setting of the register: queries of idle
		// stopwatches, start on an idle and on a running stopwatch, reset while running
		// and while idle, stop twice, ticks, undefined opcodes and every command with an
		// out-of-range index, including a tick whose index should be ignored.
		send_word(OP_STATUS, 4'd0);
		send_word(OP_READ, 4'd7);
		send_word(OP_START, 4'd0);
		send_word(OP_START, 4'd0);
		send_word(OP_START, 4'd7);
		send_word(OP_TICK, 4'd0);
		send_word(OP_TICK, 4'd15);
		send_word(OP_RESET, 4'd0);
		send_word(OP_STOP, 4'd0);
		send_word(OP_STOP, 4'd0);
		send_word(OP_RESET, 4'd0);
		send_word(OP_STATUS, 4'd0);
		send_word(OP_READ, 4'd0);
		send_word(OP_START, 4'd3);
		send_word(OP_RESET, 4'd3);
		send_word(OP_SPARE_LO, 4'd2);
		send_word(OP_SPARE_HI, 4'd15);
		send_word(OP_START, 4'd8);
		send_word(OP_STOP, 4'd15);
		send_word(OP_RESET, 4'd9);
		send_word(OP_STATUS, 4'd12);
		send_word(OP_READ, 4'd15);
		send_word(OP_STATUS, 4'd7);
		send_word(OP_START, 4'd1);
		send_word(OP_TICK, 4'd5);

		// A small setting, so counts move and the prescalers pass through their wrap.
		run_phase(16'd3, 200, 50, 50, -1, -1);
		// The largest setting: prescalers climb and no second is added. A long hold-off
		// fills the block while the sender keeps offering words.
		run_phase(16'hFFFF, 150, 50, 50, 40, -1);

		// Now the receiver idles lightly and the sender heavily.
		send_idle_pct <= 59;
		recv_idle_pct <= 18;

		// Lowering the setting below the prescalers built up in the last phase; part-way
		// through, the sender pauses until every result is in.
		run_phase(16'd2, 200, 55, 40, -1, 100);
		// One tick per second, with a second long hold-off.
		run_phase(16'd1, 300, 65, 30, 150, -1);

		// Neither side idles.
		send_idle_pct <= 0;
		recv_idle_pct <= 0;

		// A setting of zero with mostly ticks and few disturbing commands, so that
		// running counts reach saturation.
		run_phase(16'd0, 300, 88, 8, -1, -1);

		drain_results();
		// Give a stray extra result the time a tick takes to show up.
		repeat (3 * NUM_STOPWATCHES + 6) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("stopwatch_bank_core test passed");
		end else begin
			$display("stopwatch_bank_core test failed");
		end
		$finish;
	end

endmodule

@@ stopwatch_bank_core.f @@
rtl/swb_pkg.sv
rtl/swb_ram.sv
rtl/stopwatch_bank_core.sv
tb/sv/stopwatch_bank_checker.sv
tb/sv/testbench.sv
